@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the nonzero mean filter. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

// condition holds in every cycle out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)

`endif

`endif

@@ rtl/nzmf_pkg.sv @@
// ----------------------------------------------------------------------------
// nzmf_pkg
// Types, codes and the reciprocal table of the nonzero mean filter.
// ----------------------------------------------------------------------------
package nzmf_pkg;

  localparam int CFG_W    = 11;  // config register width
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W    = 12;  // row counter reaches height + 1
  localparam int SUM_W    = 12;  // nine pixels of 8 bits
  localparam int CNT_W    = 4;   // 0..9 nonzero pixels
  localparam int RCP_W    = 17;
  localparam int RCP_SHIFT = 16;
  localparam int PROD_W   = SUM_W + RCP_W;
  localparam int WIN_N    = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic [CFG_W-1:0] RESET_DIM = 11'd1024;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_value;
  } nzmf_in_t;

  typedef struct packed {
    logic [7:0] smoothed_value;
    logic       last_pixel;
  } nzmf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SUM,
    ST_MUL,
    ST_PUSH
  } nzmf_state_t;

  typedef struct packed {
    logic capture;  // latch input word, issue line store reads
    logic update;   // build new column, write stores, step window
    logic sum;      // sum and count the nonzero pixels
    logic mul;      // multiply by the reciprocal of the count
    logic push;     // load the output register
  } nzmf_cmd_t;

  typedef struct packed {
    logic emit;      // current item yields a result
    logic out_busy;  // output register holds a word not taken this cycle
  } nzmf_stat_t;

  // ceil(2^16 / n): exact floor division for sums below 2^12
  function automatic logic [RCP_W-1:0] nzmf_recip(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] r;
    unique case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/nzmf_ram.sv @@
// ----------------------------------------------------------------------------
// nzmf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nzmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/nzmf_ctrl.sv @@
// ----------------------------------------------------------------------------
// nzmf_ctrl
// Sequencer of the filter: steps one input word through update, sum,
// multiply and output load.
// ----------------------------------------------------------------------------
module nzmf_ctrl
  import nzmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  nzmf_stat_t stat,
  output nzmf_cmd_t  cmd
);

  nzmf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_PUSH;
      ST_PUSH: begin
        // hold while the previous word still sits in the output register
        if (!stat.emit || !stat.out_busy) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_UPDATE: cmd.update = 1'b1;
      ST_SUM:    cmd.sum    = 1'b1;
      ST_MUL:    cmd.mul    = 1'b1;
      ST_PUSH:   cmd.push   = stat.emit && !stat.out_busy;
      default:   cmd        = '0;
    endcase
  end

endmodule

@@ rtl/nzmf_datapath.sv @@
// ----------------------------------------------------------------------------
// nzmf_datapath
// Config registers, frame position, two line stores, 3x3 window, nonzero
// sum and count, reciprocal multiply and output register.
// ----------------------------------------------------------------------------
module nzmf_datapath
  import nzmf_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  nzmf_in_t             in_data,
  input  nzmf_cmd_t            cmd,
  output nzmf_stat_t           stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nzmf_out_t            out_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [CFG_W-1:0] width_r, height_r;
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [7:0]       win_r [WIN_N];
  logic [7:0]       win_nxt [WIN_N];
  logic [7:0]       eval_r [WIN_N];
  logic [7:0]       eval_nxt [WIN_N];
  nzmf_in_t         in_r;
  logic             emit_r, last_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0] prod_r;
  logic             out_valid_r;
  nzmf_out_t        out_r;

  logic [WW-1:0]    eff_w;
  logic [CFG_W-1:0] eff_h;
  logic [ROW_W-1:0] h_ext;
  logic [WW-1:0]    col_inc;
  logic [7:0]       above_rd, two_above_rd;
  logic [7:0]       col_new [3];
  logic             emit_nxt, last_nxt;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_DIM;
      height_r <= RESET_DIM;
    end else if (cfg_valid) begin
      if (cfg_index == REG_IMAGE_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == REG_IMAGE_HEIGHT) height_r <= cfg_data;
    end
  end

  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
  end

  assign eff_h   = (height_r == '0) ? CFG_W'(1) : height_r;
  assign h_ext   = ROW_W'(eff_h);
  assign col_inc = WW'(col_r) + WW'(1);

  nzmf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_above (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (col_r),
    .wr_data (col_new[2]),
    .rd_en   (cmd.capture),
    .rd_addr (col_r),
    .rd_data (above_rd)
  );

  nzmf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_two_above (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (col_r),
    .wr_data (above_rd),
    .rd_en   (cmd.capture),
    .rd_addr (col_r),
    .rd_data (two_above_rd)
  );

  // new column: rows r-2, r-1, r; rows outside the image read as zero
  always_comb begin
    col_new[0] = (row_r >= ROW_W'(2) && row_r <= h_ext + ROW_W'(1)) ? two_above_rd : '0;
    col_new[1] = (row_r != '0 && row_r <= h_ext) ? above_rd : '0;
    col_new[2] = (row_r < h_ext && in_r.req_type == REQ_PIXEL) ? in_r.pixel_value : '0;
    emit_nxt   = (row_r >= ROW_W'(2)) || (row_r == ROW_W'(1) && col_r != '0);
    last_nxt   = row_r > h_ext;
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_nxt[i] = win_r[i+3];
    end
    for (int i = 0; i < 3; i++) begin
      win_nxt[6+i] = col_new[i];
    end
    for (int i = 0; i < WIN_N; i++) begin
      eval_nxt[i] = win_nxt[i];
    end
    if (col_r == '0) begin
      // row start: result is the last pixel of an earlier row, right column outside
      for (int i = 6; i < WIN_N; i++) begin
        eval_nxt[i] = '0;
      end
      for (int i = 0; i < 6; i++) begin
        win_nxt[i] = '0;
      end
    end
  end

  always_comb begin
    if (last_nxt) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = CW'(col_inc);
      row_nxt = row_r;
    end
  end

  always_comb begin
    sum_nxt = '0;
    cnt_nxt = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (eval_r[i] != '0) begin
        sum_nxt = sum_nxt + SUM_W'(eval_r[i]);
        cnt_nxt = cnt_nxt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < WIN_N; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.update) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      for (int i = 0; i < WIN_N; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) emit_r <= emit_nxt;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.update) begin
      last_r <= last_nxt;
      for (int i = 0; i < WIN_N; i++) begin
        eval_r[i] <= eval_nxt[i];
      end
    end
    if (cmd.sum) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
    if (cmd.mul) prod_r <= PROD_W'(sum_r) * PROD_W'(nzmf_recip(cnt_r));
    if (cmd.push) begin
      out_r.smoothed_value <= prod_r[RCP_SHIFT +: 8];
      out_r.last_pixel     <= last_r;
    end
  end

  assign stat.emit     = emit_r;
  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

@@ rtl/nonzero_mean_filter_3x3.sv @@
// ----------------------------------------------------------------------------
// nonzero_mean_filter_3x3
// Streaming 3x3 mean over the nonzero pixels of a raster-order image.
//
//   channel  dir  word                               handshake
//   in       in   nzmf_in_t  {req_type, pixel_value} in_valid / in_ready
//   out      out  nzmf_out_t {smoothed_value, last}  out_valid / out_ready
//   cfg      in   cfg_index, cfg_data (11 bits)      cfg_valid / cfg_ready
//
// Each input word goes through capture with line store read, update, sum,
// multiply and output load; the sequencer takes one word at a time.
// The output load waits while the previous word is still held in the output
// register; the next input is taken as soon as the load is done.
// Reset sets width and height to 1024 and clears window and position; the
// line stores are not cleared. cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nonzero_mean_filter_3x3
  import nzmf_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nzmf_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nzmf_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  nzmf_cmd_t  cmd;
  nzmf_stat_t stat;

  assign cfg_ready = 1'b1;

  nzmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nzmf_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ASSERT_NEXT(a_accept_then_update, clk, rst_n, in_valid && in_ready, cmd.update)
  `ASSERT_IMPLIES(a_push_needs_room, clk, rst_n, cmd.push, !(out_valid && !out_ready))
  `ASSERT_IMPLIES(a_push_needs_emit, clk, rst_n, cmd.push, stat.emit)
  `ASSERT_ALWAYS(a_one_step, clk, rst_n, $onehot0({cmd.capture, cmd.update, cmd.sum, cmd.mul, cmd.push}))

endmodule
